// ----- src/rdd_pkg.sv -----
// Shared types and constants for the rotary detent decoder.
package rdd_pkg;

  // Counter and timeout sizing
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned DETENTS_W       = 16;
  localparam int unsigned QUIET_W         = 6;
  localparam int unsigned QUIET_TIMEOUT   = 40;
  localparam int unsigned THR_W           = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CCW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_CW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_CCW    = 2'd3;

  // Direction codes
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Phase machine codes
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CW_JUDGE  = 3'd1,
    PH_CCW_JUDGE = 3'd2,
    PH_CW_KEEP   = 3'd3,
    PH_CCW_KEEP  = 3'd4
  } phase_e;

  // Tracker state, without the detent count
  typedef struct packed {
    logic               last_a;
    logic               last_b;
    phase_e             phase;
    logic [1:0]         dir;
    logic [QUIET_W-1:0] quiet;
    logic               have;
  } track_t;

endpackage

// ----- src/rdd_in_if.sv -----
// Input channel: one encoder sample per item.
interface rdd_in_if;
  logic valid;
  logic ready;
  logic line_a;
  logic line_b;

  modport source (output valid, output line_a, output line_b, input ready);
  modport sink   (input valid, input line_a, input line_b, output ready);
endinterface

// ----- src/rdd_out_if.sv -----
// Output channel: decoder status per sample item.
interface rdd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  direction;
  logic [15:0] detents;
  logic        fire_cw;
  logic        fire_ccw;
  logic        data_valid;

  modport source (output valid, output direction, output detents, output fire_cw,
                  output fire_ccw, output data_valid, input ready);
  modport sink   (input valid, input direction, input detents, input fire_cw,
                  input fire_ccw, input data_valid, output ready);
endinterface

// ----- src/rotary_detent_decoder.sv -----
// Rotary detent decoder top level: sequencer, state, configuration and channels.
//
// Usage: each item on in_i is one sample tick of encoder lines A and B.
// For every accepted item exactly one status item leaves on out_o with the
// settled direction, the detent count, the one-item trigger pulses and the
// data-valid flag. Thresholds and trigger enables are written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port; the user must write them only while
// the block is idle, which the block itself does not enforce.
// Sequence: the block takes one item at a time. Accepting an item registers the
// updated phase machine state; if a trigger could fire, the remainder of the
// count by the threshold then runs in a bit-serial unit, one count bit at a time.
// The result is then held on out_o until taken. in_i.ready is high only while
// no item is in progress; a stalled receiver holds the block with its result
// unchanged.
// Reset: all tracker state clears, thresholds go to 1 and enables to 0;
// the block is ready straight out of reset.
module rotary_detent_decoder import rdd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rdd_in_if.sink                in_i,
  rdd_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_OUT
  } seq_e;

  seq_e                   state_q;
  track_t                 trk_q, trk_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   fire_cw_q;
  logic                   fire_ccw_q;

  logic [THR_W-1:0] thr_cw_q, thr_ccw_q;
  logic             en_cw_q, en_ccw_q;

  logic             accept;
  logic             check;
  logic [THR_W-1:0] thr_sel;
  logic             mod_done;
  logic             mod_rem_zero;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_cw_q  <= THR_W'(1);
      thr_ccw_q <= THR_W'(1);
      en_cw_q   <= 1'b0;
      en_ccw_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD_CW:  thr_cw_q  <= cfg_data_i[THR_W-1:0];
        REG_THRESHOLD_CCW: thr_ccw_q <= cfg_data_i[THR_W-1:0];
        REG_ENABLE_CW:     en_cw_q   <= cfg_data_i[0];
        REG_ENABLE_CCW:    en_ccw_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  rdd_phase #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_phase (
    .cur_i    (trk_q),
    .count_i  (count_q),
    .line_a_i (in_i.line_a),
    .line_b_i (in_i.line_b),
    .nxt_o    (trk_d),
    .count_o  (count_d)
  );

  // Trigger check needed: enabled direction, nonzero threshold, nonzero count
  always_comb begin
    thr_sel = (trk_d.dir == DIR_CW) ? thr_cw_q : thr_ccw_q;
    check   = 1'b0;
    if (trk_d.have && (count_d != '0)) begin
      if (trk_d.dir == DIR_CW) begin
        check = en_cw_q && (thr_cw_q != '0);
      end else if (trk_d.dir == DIR_CCW) begin
        check = en_ccw_q && (thr_ccw_q != '0);
      end
    end
  end

  assign accept = in_i.valid && in_i.ready;

  rdd_mod_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept && check),
    .dividend_i (count_d),
    .divisor_i  (thr_sel),
    .done_o     (mod_done),
    .rem_zero_o (mod_rem_zero)
  );

  // Sequencer with tracker state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      trk_q      <= '{last_a: 1'b0, last_b: 1'b0, phase: PH_IDLE, dir: DIR_IDLE,
                      quiet: '0, have: 1'b0};
      count_q    <= '0;
      fire_cw_q  <= 1'b0;
      fire_ccw_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            trk_q      <= trk_d;
            count_q    <= count_d;
            fire_cw_q  <= 1'b0;
            fire_ccw_q <= 1'b0;
            state_q    <= check ? S_MOD : S_OUT;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            if (mod_rem_zero) begin
              fire_cw_q  <= (trk_q.dir == DIR_CW);
              fire_ccw_q <= (trk_q.dir == DIR_CCW);
              count_q    <= '0;
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_o.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_OUT);
  assign out_o.direction  = trk_q.dir;
  assign out_o.fire_cw    = fire_cw_q;
  assign out_o.fire_ccw   = fire_ccw_q;
  assign out_o.data_valid = trk_q.have;

  // Report the low bits of the count, zero-extended for narrow counters
  if (COUNT_WIDTH >= DETENTS_W) begin : g_det_trunc
    assign out_o.detents = count_q[DETENTS_W-1:0];
  end else begin : g_det_ext
    assign out_o.detents = {{(DETENTS_W - COUNT_WIDTH){1'b0}}, count_q};
  end

endmodule

// ----- src/rdd_phase.sv -----
// Next-state logic of the quadrature phase machine, quiet timer and detent count.
module rdd_phase import rdd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  track_t                 cur_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic                   line_a_i,
  input  logic                   line_b_i,
  output track_t                 nxt_o,
  output logic [COUNT_WIDTH-1:0] count_o
);

  logic               rise_a;
  logic               rise_b;
  logic               both_low;
  logic               consult;
  logic               expire;
  logic [QUIET_W-1:0] q_inc;

  assign rise_a   = !cur_i.last_a && line_a_i;
  assign rise_b   = !cur_i.last_b && line_b_i;
  assign both_low = !line_a_i && !line_b_i;
  assign q_inc    = cur_i.quiet + QUIET_W'(1);

  // Quiet timer is only looked at in a keep phase or while a direction is settled
  always_comb begin
    case (cur_i.phase)
      PH_IDLE, PH_CW_JUDGE, PH_CCW_JUDGE: consult = (cur_i.dir != DIR_IDLE);
      PH_CW_KEEP, PH_CCW_KEEP:            consult = 1'b1;
      default:                            consult = 1'b0;
    endcase
  end

  assign expire = consult && both_low && (q_inc >= QUIET_W'(QUIET_TIMEOUT));

  always_comb begin
    nxt_o        = cur_i;
    count_o      = count_i;
    nxt_o.last_a = line_a_i;
    nxt_o.last_b = line_b_i;

    if (consult && both_low) begin
      nxt_o.quiet = expire ? '0 : q_inc;
    end

    // Timeout clears direction, count and data flag
    if (expire) begin
      nxt_o.dir   = DIR_IDLE;
      nxt_o.phase = PH_IDLE;
      nxt_o.have  = 1'b0;
      count_o     = '0;
    end

    // Edge checks still run after a timeout in idle or judge
    case (cur_i.phase)
      PH_IDLE: begin
        if (rise_a) begin
          nxt_o.phase = PH_CW_JUDGE;
        end else if (rise_b) begin
          nxt_o.phase = PH_CCW_JUDGE;
        end
      end
      PH_CW_JUDGE: begin
        if (rise_b) nxt_o.phase = PH_CW_KEEP;
      end
      PH_CCW_JUDGE: begin
        if (rise_a) nxt_o.phase = PH_CCW_KEEP;
      end
      PH_CW_KEEP, PH_CCW_KEEP: begin
        if (!expire) begin
          if (!(&count_i)) count_o = count_i + COUNT_WIDTH'(1);
          nxt_o.dir   = (cur_i.phase == PH_CW_KEEP) ? DIR_CW : DIR_CCW;
          nxt_o.phase = PH_IDLE;
        end
      end
      default: nxt_o.phase = PH_IDLE;
    endcase

    if (nxt_o.dir != DIR_IDLE) nxt_o.have = 1'b1;
  end

endmodule

// ----- src/rdd_mod_unit.sv -----
// Bit-serial restoring remainder: count mod threshold, one dividend bit per cycle.
module rdd_mod_unit import rdd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [COUNT_WIDTH-1:0] dividend_i,
  input  logic [THR_W-1:0]       divisor_i,
  output logic                   done_o,
  output logic                   rem_zero_o
);

  localparam int unsigned CNT_W = $clog2(COUNT_WIDTH + 1);

  logic [COUNT_WIDTH-1:0] dvd_q;
  logic [THR_W-1:0]       div_q;
  logic [THR_W-1:0]       rem_q, rem_d;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;
  logic [THR_W:0]         trial;

  // One restoring step: shift in the next bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[COUNT_WIDTH-1]};
    if (trial >= {1'b0, div_q}) begin
      trial = trial - {1'b0, div_q};
    end
    rem_d = trial[THR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(COUNT_WIDTH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

// ----- tb/rotary_detent_decoder_checker.sv -----
// Checker for the rotary detent decoder: tracks the encoder state, predicts and compares items.
`timescale 1ns / 100ps
module rotary_detent_decoder_checker import rdd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rdd_in_if                     sample_i,
  rdd_out_if                    status_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o
);

  // One expected status item
  typedef struct packed {
    logic [1:0]           direction;
    logic [DETENTS_W-1:0] detents;
    logic                 fire_cw;
    logic                 fire_ccw;
    logic                 data_valid;
  } status_t;

  status_t status_q[$];
  int unsigned mismatches = 0;

  // Tracker copy
  logic                       prev_a, prev_b;
  phase_e                     phase;
  logic [1:0]                 settled_dir;
  logic [QUIET_W-1:0]         quiet_cnt;
  logic [COUNT_WIDTH_DEF-1:0] detent_cnt;
  logic                       has_data;

  // Configuration copy
  logic [THR_W-1:0] thr_cw, thr_ccw;
  logic             en_cw, en_ccw;

  // A trigger is due, when enabled, on a nonzero multiple of a nonzero threshold
  function automatic logic trigger_due(input logic [THR_W-1:0] thr, input logic en,
                                       input logic [COUNT_WIDTH_DEF-1:0] cnt);
    if (thr == '0 || !en) return 1'b0;
    return (cnt >= COUNT_WIDTH_DEF'(thr)) && ((cnt % COUNT_WIDTH_DEF'(thr)) == '0);
  endfunction

  // One sample tick through the phase machine
  task automatic decode_sample(input logic a, input logic b, output status_t st);
    logic   rise_a, rise_b, timed_out;
    phase_e ph;
    rise_a = !prev_a && a;
    rise_b = !prev_b && b;
    prev_a = a;
    prev_b = b;
    ph = phase;
    timed_out = 1'b0;

    // quiet ticks count only where the counter is consulted
    if ((settled_dir != DIR_IDLE || ph == PH_CW_KEEP || ph == PH_CCW_KEEP) && !a && !b) begin
      quiet_cnt = quiet_cnt + QUIET_W'(1);
      if (quiet_cnt >= QUIET_W'(QUIET_TIMEOUT)) begin
        quiet_cnt = '0;
        timed_out = 1'b1;
      end
    end
    if (timed_out) begin
      settled_dir = DIR_IDLE;
      phase = PH_IDLE;
      detent_cnt = '0;
      has_data = 1'b0;
    end

    // edge checks still run after a timeout in idle or judge
    case (ph)
      PH_IDLE: begin
        if (rise_a) phase = PH_CW_JUDGE;
        else if (rise_b) phase = PH_CCW_JUDGE;
      end
      PH_CW_JUDGE: begin
        if (rise_b) phase = PH_CW_KEEP;
      end
      PH_CCW_JUDGE: begin
        if (rise_a) phase = PH_CCW_KEEP;
      end
      PH_CW_KEEP, PH_CCW_KEEP: begin
        if (!timed_out) begin
          if (detent_cnt != '1) detent_cnt = detent_cnt + COUNT_WIDTH_DEF'(1);
          settled_dir = (ph == PH_CW_KEEP) ? DIR_CW : DIR_CCW;
          phase = PH_IDLE;
        end
      end
      default: phase = PH_IDLE;
    endcase

    if (settled_dir != DIR_IDLE) has_data = 1'b1;

    st.fire_cw = 1'b0;
    st.fire_ccw = 1'b0;
    if (has_data) begin
      if (settled_dir == DIR_CW && trigger_due(thr_cw, en_cw, detent_cnt)) begin
        st.fire_cw = 1'b1;
        detent_cnt = '0;
      end else if (settled_dir == DIR_CCW && trigger_due(thr_ccw, en_ccw, detent_cnt)) begin
        st.fire_ccw = 1'b1;
        detent_cnt = '0;
      end
    end
    st.direction = settled_dir;
    st.detents = detent_cnt[DETENTS_W-1:0];
    st.data_valid = has_data;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  // Watch the config port and both channels
  always @(posedge clk_i) begin
    status_t want;
    if (!rst_ni) begin
      prev_a = 1'b0;
      prev_b = 1'b0;
      phase = PH_IDLE;
      settled_dir = DIR_IDLE;
      quiet_cnt = '0;
      detent_cnt = '0;
      has_data = 1'b0;
      thr_cw = 8'd1;
      thr_ccw = 8'd1;
      en_cw = 1'b0;
      en_ccw = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD_CW:  thr_cw = cfg_data_i;
          REG_THRESHOLD_CCW: thr_ccw = cfg_data_i;
          REG_ENABLE_CW:     en_cw = cfg_data_i[0];
          REG_ENABLE_CCW:    en_ccw = cfg_data_i[0];
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready) begin
        decode_sample(sample_i.line_a, sample_i.line_b, want);
        status_q.push_back(want);
      end
      if (status_i.valid && status_i.ready) begin
        if (status_q.size() == 0) begin
          mismatches++;
          $error("status item with no sample pending");
        end else begin
          want = status_q.pop_front();
          check_field("direction", 32'(want.direction), 32'(status_i.direction));
          check_field("detents", 32'(want.detents), 32'(status_i.detents));
          check_field("fire_cw", 32'(want.fire_cw), 32'(status_i.fire_cw));
          check_field("fire_ccw", 32'(want.fire_ccw), 32'(status_i.fire_ccw));
          check_field("data_valid", 32'(want.data_valid), 32'(status_i.data_valid));
        end
      end
    end
    pending_o <= status_q.size();
    mismatches_o <= mismatches;
  end

endmodule

// ----- tb/rotary_detent_decoder_tb.sv -----
// Testbench top for the rotary detent decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module rotary_detent_decoder_tb;
  import rdd_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           pending;
  int unsigned           mismatches;
  int unsigned           idle_pct = 0;
  int unsigned           stall_pct = 0;
  int unsigned           samples_sent = 0;

  rdd_in_if  sample_ch ();
  rdd_out_if status_ch ();

  rotary_detent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (sample_ch),
    .out_o      (status_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  rotary_detent_decoder_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_ch),
    .status_i     (status_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    status_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one sample item after a random gap and wait for acceptance
  task automatic send_sample(input logic a, input logic b);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.line_a <= a;
    sample_ch.line_b <= b;
    @(posedge clk_i);
    while (!(sample_ch.valid && sample_ch.ready)) @(posedge clk_i);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
  endtask

  // Drain, then rewrite every register
  task automatic configure(input logic [CFG_DATA_W-1:0] thr_cw, input logic [CFG_DATA_W-1:0] thr_ccw,
                           input logic [CFG_DATA_W-1:0] en_cw, input logic [CFG_DATA_W-1:0] en_ccw);
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    write_reg(REG_THRESHOLD_CW, thr_cw);
    write_reg(REG_THRESHOLD_CCW, thr_ccw);
    write_reg(REG_ENABLE_CW, en_cw);
    write_reg(REG_ENABLE_CCW, en_ccw);
    cfg_we <= 1'b0;
  endtask

  // Well-formed detent: release, leading edge, trailing edge, then a random keep tick
  task automatic turn_detent(input logic cw);
    logic [1:0] keep_lines;
    logic       spare;
    keep_lines = 2'($urandom_range(3));
    spare = 1'($urandom_range(1));
    if (cw) begin
      send_sample(1'b0, spare);
      send_sample(1'b1, 1'b0);
    end else begin
      send_sample(spare, 1'b0);
      send_sample(1'b0, 1'b1);
    end
    send_sample(1'b1, 1'b1);
    send_sample(keep_lines[1], keep_lines[0]);
  endtask

  // Mostly detent bursts, some stalled turns with quiet stretches, some noise
  task automatic run_random(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic        cw;
    start = samples_sent;
    while (samples_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        n = $urandom_range(1, 6);
        cw = 1'($urandom_range(1));
        repeat (n) turn_detent(cw);
      end else if (pick < 75) begin
        if ($urandom_range(1)) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
        n = $urandom_range(1, 50);
        repeat (n) send_sample(1'b0, 1'b0);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [1:0] lines[$];
    sample_ch.valid = 1'b0;
    sample_ch.line_a = 1'b0;
    sample_ch.line_b = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_THRESHOLD_CW;
    cfg_data = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset config: cw and ccw detents counted, no trigger, both lines high
    lines = '{2'b00, 2'b10, 2'b11, 2'b01, 2'b00, 2'b01, 2'b11, 2'b10, 2'b11};
    foreach (lines[i]) send_sample(lines[i][1], lines[i][0]);

    // Threshold extremes, enables masked to bit 0
    configure(8'd1, 8'd255, 8'h01, 8'hFE);
    lines = '{2'b00, 2'b10, 2'b11, 2'b01, 2'b00, 2'b10, 2'b11, 2'b01,
              2'b00, 2'b01, 2'b11, 2'b10};
    foreach (lines[i]) send_sample(lines[i][1], lines[i][0]);

    configure(8'd1, 8'd1, 8'h01, 8'h01);
    idle_pct = 0;
    stall_pct = 0;
    run_random(170);

    // zero threshold never fires
    configure(8'd0, 8'd2, 8'hFF, 8'h01);
    idle_pct = 88;
    stall_pct = 0;
    run_random(170);

    configure(8'd255, 8'd3, 8'h01, 8'hFD);
    idle_pct = 0;
    stall_pct = 88;
    run_random(170);

    configure(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
    idle_pct = 10;
    stall_pct = 10;
    run_random(170);

    // Drain and settle
    sample_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
